[src/bale_pkg.sv]
package bale_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int POS_W        = 4;
  localparam int ST_W         = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_SEARCH   = 3'd1,
    OP_UPDATE   = 3'd2,
    OP_DELETE   = 3'd3,
    OP_TRAVERSE = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH,
    S_DEL,
    S_TRAV,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_CLEAR,
    IDX_LOAD_POS,
    IDX_INC
  } idx_cmd_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_cmd_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_APPEND,
    WR_UPDATE,
    WR_SHIFT
  } wr_cmd_t;

  typedef struct packed {
    logic     load_in;
    idx_cmd_t idx_cmd;
    logic     rd_ahead;
    cnt_cmd_t cnt_cmd;
    wr_cmd_t  wr_cmd;
    logic     out_load;
    status_t  out_status;
    logic     out_pos_idx;
    logic     out_val_rd;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic pos_ok;
    logic del_short;
    logic match;
    logic idx_last;
    logic del_end;
    logic out_last;
  } sts_t;

endpackage

[src/bale_in_if.sv]
interface bale_in_if
  import bale_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [DATA_W-1:0] data_value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output opcode, output data_value, output position,
                  input ready);
  modport sink   (input valid, input opcode, input data_value, input position,
                  output ready);
endinterface

[src/bale_out_if.sv]
interface bale_out_if
  import bale_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic [POS_W-1:0]         found_position;
  logic signed [DATA_W-1:0] element_value;
  logic                     last;

  modport source (output valid, output status, output found_position,
                  output element_value, output last, input ready);
  modport sink   (input valid, input status, input found_position,
                  input element_value, input last, output ready);
endinterface

[src/bale_ctrl.sv]
module bale_ctrl
  import bale_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_INSERT, OP_UPDATE: state_nxt = S_OUT;
          OP_SEARCH: state_nxt = sts.empty ? S_OUT : S_SRCH;
          OP_DELETE: state_nxt = (!sts.pos_ok || sts.del_short) ? S_OUT : S_DEL;
          OP_TRAVERSE: state_nxt = sts.empty ? S_OUT : S_TRAV;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SRCH: begin
        if (sts.match || sts.idx_last) state_nxt = S_OUT;
      end
      S_DEL: begin
        if (sts.del_end) state_nxt = S_OUT;
      end
      S_TRAV: state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) state_nxt = sts.out_last ? S_IDLE : S_TRAV;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    cmd.load_in     = 1'b0;
    cmd.idx_cmd     = IDX_HOLD;
    cmd.rd_ahead    = 1'b0;
    cmd.cnt_cmd     = CNT_HOLD;
    cmd.wr_cmd      = WR_NONE;
    cmd.out_load    = 1'b0;
    cmd.out_status  = ST_OK;
    cmd.out_pos_idx = 1'b0;
    cmd.out_val_rd  = 1'b0;
    cmd.out_last    = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_INSERT: begin
            cmd.out_load = 1'b1;
            if (sts.full) begin
              cmd.out_status = ST_FULL;
            end else begin
              cmd.wr_cmd  = WR_APPEND;
              cmd.cnt_cmd = CNT_INC;
            end
          end
          OP_SEARCH: begin
            if (sts.empty) begin
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_NOT_FOUND;
            end else begin
              cmd.idx_cmd = IDX_CLEAR;
            end
          end
          OP_UPDATE: begin
            cmd.out_load = 1'b1;
            if (sts.pos_ok) cmd.wr_cmd = WR_UPDATE;
            else cmd.out_status = ST_BAD_INDEX;
          end
          OP_DELETE: begin
            if (!sts.pos_ok) begin
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_BAD_INDEX;
            end else if (sts.del_short) begin
              cmd.out_load = 1'b1;
              cmd.cnt_cmd  = CNT_DEC;
            end else begin
              cmd.idx_cmd  = IDX_LOAD_POS;
              cmd.rd_ahead = 1'b1;
            end
          end
          OP_TRAVERSE: begin
            if (sts.empty) begin
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_EMPTY;
            end else begin
              cmd.idx_cmd = IDX_CLEAR;
            end
          end
          default: ;
        endcase
      end
      S_SRCH: begin
        if (sts.match) begin
          cmd.out_load    = 1'b1;
          cmd.out_pos_idx = 1'b1;
        end else if (sts.idx_last) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_NOT_FOUND;
        end else begin
          cmd.idx_cmd = IDX_INC;
        end
      end
      S_DEL: begin
        cmd.wr_cmd   = WR_SHIFT;
        cmd.rd_ahead = 1'b1;
        if (sts.del_end) begin
          cmd.cnt_cmd  = CNT_DEC;
          cmd.out_load = 1'b1;
        end else begin
          cmd.idx_cmd = IDX_INC;
        end
      end
      S_TRAV: begin
        cmd.out_load   = 1'b1;
        cmd.out_val_rd = 1'b1;
        cmd.out_last   = sts.idx_last;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready && !sts.out_last) cmd.idx_cmd = IDX_INC;
      end
      default: ;
    endcase
  end

endmodule

[src/bale_dp.sv]
module bale_dp
  import bale_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic signed [DATA_W-1:0] in_data_value,
  input  logic [POS_W-1:0]         in_position,
  output logic [ST_W-1:0]          out_status,
  output logic [POS_W-1:0]         out_found_position,
  output logic signed [DATA_W-1:0] out_element_value,
  output logic                     out_last
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic signed [DATA_W-1:0] mem [CAPACITY];

  logic [OP_W-1:0]          op_r;
  logic signed [DATA_W-1:0] val_r;
  logic [POS_W-1:0]         pos_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic signed [DATA_W-1:0] rd_data_r;
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic [CMP_W-1:0]         pos_ext, count_ext, idx_ext;

  logic [ST_W-1:0]          status_r;
  logic [POS_W-1:0]         found_r;
  logic signed [DATA_W-1:0] elem_r;
  logic                     last_r;

  assign pos_ext   = CMP_W'(pos_r);
  assign count_ext = CMP_W'(count_r);
  assign idx_ext   = CMP_W'(idx_r);

  always_comb begin
    case (cmd.idx_cmd)
      IDX_CLEAR:    idx_nxt = '0;
      IDX_LOAD_POS: idx_nxt = IDX_W'(pos_ext);
      IDX_INC:      idx_nxt = idx_r + IDX_W'(1);
      default:      idx_nxt = idx_r;
    endcase
  end

  // delete reads one entry ahead of the slot being written
  assign rd_addr = cmd.rd_ahead ? (idx_nxt + IDX_W'(1)) : idx_nxt;

  always_comb begin
    case (cmd.cnt_cmd)
      CNT_INC: count_nxt = count_r + CNT_W'(1);
      CNT_DEC: count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_comb begin
    case (cmd.wr_cmd)
      WR_APPEND: begin
        wr_addr = count_r[IDX_W-1:0];
        wr_data = val_r;
      end
      WR_UPDATE: begin
        wr_addr = IDX_W'(pos_ext);
        wr_data = val_r;
      end
      default: begin
        wr_addr = idx_r;
        wr_data = rd_data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_cmd != WR_NONE) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load_in) begin
      op_r  <= in_opcode;
      val_r <= in_data_value;
      pos_r <= in_position;
    end
    if (cmd.out_load) begin
      status_r <= cmd.out_status;
      found_r  <= cmd.out_pos_idx ? idx_ext[POS_W-1:0] : '0;
      elem_r   <= cmd.out_val_rd ? rd_data_r : '0;
      last_r   <= cmd.out_last;
    end
  end

  assign sts.op        = op_t'(op_r);
  assign sts.full      = (count_r >= CNT_W'(CAPACITY));
  assign sts.empty     = (count_r == '0);
  assign sts.pos_ok    = (pos_ext < count_ext);
  assign sts.del_short = ((pos_ext + CMP_W'(1)) == count_ext);
  assign sts.match     = (rd_data_r == val_r);
  assign sts.idx_last  = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign sts.del_end   = ((CNT_W'(idx_r) + CNT_W'(2)) == count_r);
  assign sts.out_last  = last_r;

  assign out_status         = status_r;
  assign out_found_position = found_r;
  assign out_element_value  = elem_r;
  assign out_last           = last_r;

endmodule

[src/bounded_array_list_engine_unit.sv]
// bounded array list engine: an ordered list of up to CAPACITY signed 32-bit values held
// in a single-port-read, single-port-write memory with a fill count. one request is
// handled at a time; the input is ready only when the previous request's results have
// all been taken. insert and update go from accept through dispatch straight to the
// result; search and delete walk the memory one entry per cycle through its one
// registered read port; traverse reads each entry, then presents it, and reads the
// next only after the sink has taken that result. after reset the list is empty and
// usable at once; stored entries need no clearing. undefined opcodes are taken and
// dropped with no result.
module bounded_array_list_engine_unit
  import bale_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst_n,
  bale_in_if.sink   in_ch,
  bale_out_if.source out_ch
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: request accept, table walks, result hand-off
  bale_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: request latch, entry memory, fill count, walk index, result register
  bale_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_ch.opcode),
    .in_data_value      (in_ch.data_value),
    .in_position        (in_ch.position),
    .out_status         (out_ch.status),
    .out_found_position (out_ch.found_position),
    .out_element_value  (out_ch.element_value),
    .out_last           (out_ch.last)
  );

endmodule
